// ===== rtl/tse_pkg.sv =====
// Shared types and constants for the Taylor-series exp/sin/cos/ln(1+x) evaluator.
// Holds the command codes, sequencer states, micro-operations and shift selects.
// No dependencies.
`default_nettype none

package tse_pkg;

  // Field widths of the stream payloads.
  localparam int CMD_W = 2;
  localparam int X_W = 32;
  localparam int RES_W = 64;

  // Term limit register.
  localparam int TERM_LIMIT_W = 5;
  localparam logic [TERM_LIMIT_W-1:0] TERM_LIMIT_RST = 5'd14;
  // Number of indexes that the term limit register can address.
  localparam int TERM_IDX_SPAN = 32;

  // Default bound on the ln(1+x) series index (exclusive).
  localparam int LN_TERM_BOUND_DEF = 30;

  // Function select carried on the input tuser.
  typedef enum logic [CMD_W-1:0] {
    CMD_EXP  = 2'd0,
    CMD_SIN  = 2'd1,
    CMD_COS  = 2'd2,
    CMD_LN1P = 2'd3
  } cmd_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_OP_SEL,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_FIN,
    ST_DONE
  } state_t;

  // Micro-operations applied to the running term.
  typedef enum logic [2:0] {
    OP_TX,       // times x, result shifted by 24
    OP_DV_PREV,  // divide by i-1 through the reciprocal table
    OP_DV,       // divide by i through the reciprocal table
    OP_MK,       // exact multiply by i-1
    OP_ACC       // add the term into the sum
  } op_t;

  // Right shift applied after the scale multiply.
  typedef enum logic [1:0] {
    SH_0,
    SH_24,
    SH_32
  } shift_t;

endpackage

`default_nettype wire

// ===== rtl/taylor_series_exp_sin_cos_ln.sv =====
// Taylor-series evaluator on one shared 32x32 multiplier, one item at a time. A scale step
// runs operand select, two partial products and round/saturate in turn; adding a term and
// the loop test are separate steps. A new input is taken only once the last result has been
// handed to the output register; a saturation ends an item early, a stalled out holds it back.
// Reset (rst_n low, synchronous) sets the term limit to 14, idles the sequencer, drops out_tvalid.
`default_nettype none

module taylor_series_exp_sin_cos_ln #(
  parameter int LN_TERM_BOUND = tse_pkg::LN_TERM_BOUND_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Configuration: term_limit
  input  wire logic                            cfg_wr_en,
  input  wire logic [tse_pkg::TERM_LIMIT_W-1:0] cfg_wr_data,
  // Input stream
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [tse_pkg::X_W-1:0]         in_tdata,   // [31:0] x_value (Q8.24)
  input  wire logic [tse_pkg::CMD_W-1:0]       in_tuser,   // [1:0] cmd
  // Result stream
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [tse_pkg::RES_W-1:0]            out_tdata,  // [63:0] result_value (Q31.32)
  output logic [0:0]                           out_tuser   // [0] overflow
);
  import tse_pkg::*;

  // Number of series indexes that the reciprocal table covers.
  localparam int NMAX = (LN_TERM_BOUND > TERM_IDX_SPAN) ? LN_TERM_BOUND : TERM_IDX_SPAN;
  localparam int NW = $clog2(NMAX);
  localparam int CW = $clog2(NMAX + 1);

  localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;
  localparam logic [63:0] SUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SUM_MIN = 64'h8000_0000_0000_0000;

  // Reciprocal table: R(n) = floor((2^32 + floor(n/2)) / n), built at elaboration.
  logic [31:0] recip_tab [NMAX];
  for (genvar g = 0; g < NMAX; g++) begin : g_recip
    localparam logic [63:0] RV = ((64'd1 << 32) + 64'(g / 2)) / 64'((g < 2) ? 2 : g);
    assign recip_tab[g] = (g < 2) ? 32'd0 : RV[31:0];
  end

  // Registers
  state_t              state_r, state_nxt;
  logic [TERM_LIMIT_W-1:0] term_limit_r;
  cmd_t                cmd_r, cmd_nxt;
  logic                xneg_r, xneg_nxt;
  logic [31:0]         xm_r, xm_nxt;
  logic [63:0]         sum_r, sum_nxt;
  logic                ovf_r, ovf_nxt;
  logic [63:0]         t_r, t_nxt;
  logic [CW-1:0]       i_r, i_nxt;
  logic [2:0]          step_r, step_nxt;
  logic [63:0]         mag_r, mag_nxt;
  logic [31:0]         m_r, m_nxt;
  logic                rneg_r, rneg_nxt;
  shift_t              sh_r, sh_nxt;
  logic [63:0]         plo_r, plo_nxt;
  logic [63:0]         phi_r, phi_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [63:0]         out_data_r, out_data_nxt;
  logic                out_ovf_r, out_ovf_nxt;

  // Shared multiplier: low half of the magnitude first, then the high half.
  logic [31:0] mul_a;
  logic [63:0] mul_p;
  assign mul_a = (state_r == ST_MUL_HI) ? mag_r[63:32] : mag_r[31:0];
  assign mul_p = mul_a * m_r;

  // Round, shift and saturate the 96-bit product.
  logic [95:0] prod;
  logic [96:0] half, rnd, rsh, lim;
  logic        sc_ovf;
  logic [63:0] sc_mag, sc_val;
  always_comb begin
    prod = {phi_r, 32'd0} + {32'd0, plo_r};
    case (sh_r)
      SH_24:   half = 97'd1 << 23;
      SH_32:   half = 97'd1 << 31;
      default: half = 97'd0;
    endcase
    rnd = {1'b0, prod} + half;
    case (sh_r)
      SH_24:   rsh = rnd >> 24;
      SH_32:   rsh = rnd >> 32;
      default: rsh = rnd;
    endcase
    lim = rneg_r ? {33'd0, 1'b1, 63'd0} : {34'd0, {63{1'b1}}};
    sc_ovf = rsh > lim;
    sc_mag = rsh[63:0];
    sc_val = rneg_r ? (64'd0 - sc_mag) : sc_mag;
  end

  // Sign of the current term in the sum: sin and cos alternate, ln subtracts even terms.
  logic term_sub;
  always_comb begin
    case (cmd_r)
      CMD_SIN, CMD_COS: term_sub = i_r[1];
      CMD_LN1P:         term_sub = ~i_r[0];
      default:          term_sub = 1'b0;
    endcase
  end

  // Micro-operation for the current index and step.
  op_t op;
  always_comb begin
    op = OP_ACC;
    case (cmd_r)
      CMD_EXP: begin
        case (step_r)
          3'd0:    op = OP_TX;
          3'd1:    op = OP_DV;
          default: op = OP_ACC;
        endcase
      end
      CMD_SIN, CMD_COS: begin
        if (i_r == CW'(1)) begin
          op = OP_ACC;
        end else if (i_r == CW'(2)) begin
          case (step_r)
            3'd0:    op = OP_TX;
            3'd1:    op = OP_DV;
            default: op = OP_ACC;
          endcase
        end else begin
          case (step_r)
            3'd0:    op = OP_DV_PREV;
            3'd1:    op = OP_DV;
            3'd2:    op = OP_TX;
            3'd3:    op = OP_TX;
            default: op = OP_ACC;
          endcase
        end
      end
      default: begin
        if (i_r == CW'(2)) begin
          case (step_r)
            3'd0:    op = OP_TX;
            3'd1:    op = OP_DV;
            default: op = OP_ACC;
          endcase
        end else begin
          case (step_r)
            3'd0:    op = OP_MK;
            3'd1:    op = OP_TX;
            3'd2:    op = OP_DV;
            default: op = OP_ACC;
          endcase
        end
      end
    endcase
  end

  // Index arithmetic and loop test.
  logic [CW-1:0] i_prev, lim_ext;
  logic          cont;
  always_comb begin
    i_prev = i_r - CW'(1);
    lim_ext = CW'(term_limit_r);
    case (cmd_r)
      CMD_SIN:  cont = (i_r + CW'(1)) <= lim_ext;
      CMD_LN1P: cont = i_r < CW'(LN_TERM_BOUND);
      default:  cont = i_r <= lim_ext;
    endcase
  end

  // Saturating accumulate.
  logic [64:0] acc65;
  logic        acc_ovf;
  always_comb begin
    if (term_sub) begin
      acc65 = {sum_r[63], sum_r} - {t_r[63], t_r};
    end else begin
      acc65 = {sum_r[63], sum_r} + {t_r[63], t_r};
    end
    acc_ovf = acc65[64] ^ acc65[63];
  end

  // Input decode.
  logic        in_neg;
  logic [31:0] in_mag;
  logic [63:0] in_x32;
  always_comb begin
    in_neg = in_tdata[31];
    in_mag = in_neg ? (32'd0 - in_tdata) : in_tdata;
    in_x32 = in_neg ? (64'd0 - {24'd0, in_mag, 8'd0}) : {24'd0, in_mag, 8'd0};
  end

  assign in_tready = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_ovf_r;

  // Sequencer next state and datapath updates.
  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r;
    xneg_nxt = xneg_r;
    xm_nxt = xm_r;
    sum_nxt = sum_r;
    ovf_nxt = ovf_r;
    t_nxt = t_r;
    i_nxt = i_r;
    step_nxt = step_r;
    mag_nxt = mag_r;
    m_nxt = m_r;
    rneg_nxt = rneg_r;
    sh_nxt = sh_r;
    plo_nxt = plo_r;
    phi_nxt = phi_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt = out_data_r;
    out_ovf_nxt = out_ovf_r;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt = cmd_t'(in_tuser);
          xneg_nxt = in_neg;
          xm_nxt = in_mag;
          t_nxt = in_x32;
          ovf_nxt = 1'b0;
          step_nxt = 3'd0;
          case (cmd_t'(in_tuser))
            CMD_EXP: begin
              sum_nxt = ONE_Q32 + in_x32;
              i_nxt = CW'(2);
            end
            CMD_SIN: begin
              sum_nxt = 64'd0;
              i_nxt = CW'(1);
            end
            CMD_COS: begin
              sum_nxt = ONE_Q32;
              i_nxt = CW'(2);
            end
            default: begin
              sum_nxt = in_x32;
              i_nxt = CW'(2);
            end
          endcase
          state_nxt = ST_CHECK;
        end
      end

      ST_CHECK: begin
        step_nxt = 3'd0;
        state_nxt = cont ? ST_OP_SEL : ST_DONE;
      end

      // Load the scale unit operands, or add the finished term.
      ST_OP_SEL: begin
        mag_nxt = t_r[63] ? (64'd0 - t_r) : t_r;
        case (op)
          OP_TX: begin
            m_nxt = xm_r;
            rneg_nxt = t_r[63] ^ xneg_r;
            sh_nxt = SH_24;
            state_nxt = ST_MUL_LO;
          end
          OP_DV_PREV: begin
            m_nxt = recip_tab[i_prev[NW-1:0]];
            rneg_nxt = t_r[63];
            sh_nxt = SH_32;
            state_nxt = ST_MUL_LO;
          end
          OP_DV: begin
            m_nxt = recip_tab[i_r[NW-1:0]];
            rneg_nxt = t_r[63];
            sh_nxt = SH_32;
            state_nxt = ST_MUL_LO;
          end
          OP_MK: begin
            m_nxt = 32'(i_prev);
            rneg_nxt = t_r[63];
            sh_nxt = SH_0;
            state_nxt = ST_MUL_LO;
          end
          default: begin
            if (acc_ovf) begin
              sum_nxt = acc65[64] ? SUM_MIN : SUM_MAX;
              ovf_nxt = 1'b1;
              state_nxt = ST_DONE;
            end else begin
              sum_nxt = acc65[63:0];
              if (cmd_r == CMD_SIN || cmd_r == CMD_COS) begin
                i_nxt = i_r + CW'(2);
              end else begin
                i_nxt = i_r + CW'(1);
              end
              state_nxt = ST_CHECK;
            end
          end
        endcase
      end

      ST_MUL_LO: begin
        plo_nxt = mul_p;
        state_nxt = ST_MUL_HI;
      end

      ST_MUL_HI: begin
        phi_nxt = mul_p;
        state_nxt = ST_FIN;
      end

      // A saturated term ends the series with the sum pinned at a bound.
      ST_FIN: begin
        if (sc_ovf) begin
          sum_nxt = (rneg_r != term_sub) ? SUM_MIN : SUM_MAX;
          ovf_nxt = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          t_nxt = sc_val;
          step_nxt = step_r + 3'd1;
          state_nxt = ST_OP_SEL;
        end
      end

      // Hand the result to the output register once it is free.
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = sum_r;
          out_ovf_nxt = ovf_r;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      term_limit_r <= TERM_LIMIT_RST;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        term_limit_r <= cfg_wr_data;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    xneg_r <= xneg_nxt;
    xm_r <= xm_nxt;
    sum_r <= sum_nxt;
    ovf_r <= ovf_nxt;
    t_r <= t_nxt;
    i_r <= i_nxt;
    step_r <= step_nxt;
    mag_r <= mag_nxt;
    m_r <= m_nxt;
    rneg_r <= rneg_nxt;
    sh_r <= sh_nxt;
    plo_r <= plo_nxt;
    phi_r <= phi_nxt;
    out_data_r <= out_data_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

endmodule

`default_nettype wire
